// ----- sv/numeric_literal_classifier_assert.svh -----
// Assertion macros used by the port-level assertion module of the literal classifier.
`ifndef NUMERIC_LITERAL_CLASSIFIER_ASSERT_SVH
`define NUMERIC_LITERAL_CLASSIFIER_ASSERT_SVH

// Checked on every rising edge outside reset.
`define NLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset cycles included.
`define NLC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/nlc_pkg.sv -----
// Shared types, character codes and automaton step functions of the literal classifier.
`default_nettype none

package nlc_pkg;

  // Word classes, in priority order
  typedef enum logic [1:0] {
    CLS_DEC  = 2'd0,
    CLS_OCT  = 2'd1,
    CLS_HEX  = 2'd2,
    CLS_NONE = 2'd3
  } cls_t;

  localparam int NUM_CLASSES = 4;
  localparam int OUT_CNT_W   = 16;

  // Lone-zero tracker codes
  typedef enum logic [1:0] {
    LZ_EMPTY = 2'd0,
    LZ_ZERO  = 2'd1,
    LZ_OTHER = 2'd2
  } lz_t;

  // Character codes
  localparam logic [7:0] CHAR_SEP   = 8'h24;  // '$'
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_F  = 8'h46;
  localparam logic [7:0] CHAR_LC_X  = 8'h78;

  // Automaton states
  localparam logic [1:0] DEC_START = 2'd0;
  localparam logic [1:0] DEC_SIGN  = 2'd1;
  localparam logic [1:0] DEC_FINAL = 2'd2;
  localparam logic [1:0] DEC_DEAD  = 2'd3;
  localparam logic [1:0] OCT_START = 2'd0;
  localparam logic [1:0] OCT_FINAL = 2'd1;
  localparam logic [1:0] OCT_DEAD  = 2'd2;
  localparam logic [2:0] HEX_START = 3'd0;
  localparam logic [2:0] HEX_ZERO  = 3'd1;
  localparam logic [2:0] HEX_PFX   = 3'd2;
  localparam logic [2:0] HEX_FINAL = 3'd3;
  localparam logic [2:0] HEX_DEAD  = 3'd4;

  // Alphabet flag bits
  localparam int OK_DEC = 0;
  localparam int OK_OCT = 1;
  localparam int OK_HEX = 2;

  // Character kinds seen by the automata
  typedef struct packed {
    logic sign;
    logic zero;
    logic nonzero;
    logic octal;
    logic hex_letter;
    logic x;
  } char_kind_t;

  // Tracker to counter hand-off
  typedef struct packed {
    logic ended;
    cls_t cls;
  } word_result_t;

  // Decimal: sign, zero, nonzero digit columns
  function automatic logic [1:0] dec_step(input logic [1:0] st, input char_kind_t k);
    logic [1:0] nxt;
    nxt = DEC_DEAD;
    if (k.sign) begin
      nxt = (st == DEC_START) ? DEC_SIGN : DEC_DEAD;
    end else if (k.zero) begin
      nxt = (st == DEC_FINAL) ? DEC_FINAL : DEC_DEAD;
    end else if (k.nonzero) begin
      nxt = (st == DEC_DEAD) ? DEC_DEAD : DEC_FINAL;
    end
    return nxt;
  endfunction

  // Octal: zero, digit 1-7 columns
  function automatic logic [1:0] oct_step(input logic [1:0] st, input char_kind_t k);
    logic [1:0] nxt;
    nxt = OCT_DEAD;
    if (k.zero || k.octal) begin
      case (st)
        OCT_START: nxt = k.zero ? OCT_FINAL : OCT_DEAD;
        OCT_FINAL: nxt = OCT_FINAL;
        default:   nxt = OCT_DEAD;
      endcase
    end
    return nxt;
  endfunction

  // Hexadecimal: 'x', zero, digit or A-F columns
  function automatic logic [2:0] hex_step(input logic [2:0] st, input char_kind_t k);
    logic [2:0] nxt;
    nxt = HEX_DEAD;
    if (k.x) begin
      nxt = (st == HEX_ZERO) ? HEX_PFX : HEX_DEAD;
    end else if (k.zero) begin
      case (st)
        HEX_START: nxt = HEX_ZERO;
        HEX_PFX:   nxt = HEX_FINAL;
        HEX_FINAL: nxt = HEX_FINAL;
        default:   nxt = HEX_DEAD;
      endcase
    end else if (k.nonzero || k.hex_letter) begin
      nxt = (st == HEX_PFX || st == HEX_FINAL) ? HEX_FINAL : HEX_DEAD;
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

// ----- sv/numeric_literal_classifier.sv -----
// Top level of the numeric literal classifier: input stage, word logic, result stage.
//
//  Channel | Ports              | tdata                         | tuser / tlast
//  --------+--------------------+-------------------------------+----------------------
//  in      | in_t{valid,ready}  | [7:0] character               | tlast: final_char
//  out     | out_t{valid,ready} | dec, oct, hex, other counts   | tuser[1:0]: word_class
//
// One character per cycle while no pending result stalls the input; a word's result is
// offered once its ending character has passed the input register, then the result
// register. The per-word automata step once per request in combinational logic.
// rst_n (synchronous) clears word state, counters and both valid flags.
// A stalled result holds the output register; the input register still drains
// characters that end no word, and stalls only behind a pending result.
`default_nettype none

module numeric_literal_classifier #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic        in_tlast,   // final_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [15:0] decimal_count, [31:16] octal_count,
                                  // [47:32] hex_count, [63:48] other_count
  output logic [1:0]  out_tuser   // [1:0] word_class
);
  import nlc_pkg::*;

  logic                                     s1_valid_r;
  logic [7:0]                               s1_char_r;
  logic                                     s1_last_r;
  logic                                     s1_fire;
  logic                                     out_free;
  logic                                     out_valid_r;
  logic [63:0]                              out_data_r;
  cls_t                                     out_cls_r;
  word_result_t                             result;
  logic [NUM_CLASSES-1:0][OUT_CNT_W-1:0]    count_out;

  // Handshake: stage 1 moves on unless it carries a result and the output is full
  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && (!result.ended || out_free);
  assign in_tready = !s1_valid_r || s1_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_char_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  nlc_word_tracker u_word (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_fire),
    .char_in (s1_char_r),
    .last_in (s1_last_r),
    .result  (result)
  );

  nlc_class_counter #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_fire),
    .result    (result),
    .count_out (count_out)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && result.ended) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && result.ended) begin
      out_data_r <= count_out;
      out_cls_r  <= result.cls;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_cls_r;

endmodule

`default_nettype wire

// ----- sv/nlc_word_tracker.sv -----
// Per-word automata, alphabet flags, lone-zero tracker and word classification.
`default_nettype none

module nlc_word_tracker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic [7:0]            char_in,
  input  logic                  last_in,
  output nlc_pkg::word_result_t result
);
  import nlc_pkg::*;

  logic [1:0] dec_r, dec_nxt, dec_tk;
  logic [1:0] oct_r, oct_nxt, oct_tk;
  logic [2:0] hex_r, hex_nxt, hex_tk;
  logic [2:0] ok_r, ok_nxt, ok_tk;
  lz_t        lz_r, lz_nxt, lz_tk;
  char_kind_t kind;
  logic       is_sep;
  logic       ended;
  cls_t       cls;

  // Character decode
  always_comb begin
    is_sep          = (char_in == CHAR_SEP);
    kind.sign       = (char_in == CHAR_PLUS) || (char_in == CHAR_MINUS);
    kind.zero       = (char_in == CHAR_ZERO);
    kind.nonzero    = char_in inside {[CHAR_ONE:CHAR_NINE]};
    kind.octal      = char_in inside {[CHAR_ONE:CHAR_SEVEN]};
    kind.hex_letter = char_in inside {[CHAR_UC_A:CHAR_UC_F]};
    kind.x          = (char_in == CHAR_LC_X);
  end

  // Word state after taking the character (separator is not taken)
  always_comb begin
    dec_tk = dec_r;
    oct_tk = oct_r;
    hex_tk = hex_r;
    ok_tk  = ok_r;
    lz_tk  = lz_r;
    if (!is_sep) begin
      dec_tk = dec_step(dec_r, kind);
      oct_tk = oct_step(oct_r, kind);
      hex_tk = hex_step(hex_r, kind);
      if (!(kind.sign || kind.zero || kind.nonzero)) ok_tk[OK_DEC] = 1'b0;
      if (!(kind.zero || kind.octal)) ok_tk[OK_OCT] = 1'b0;
      if (!(kind.x || kind.zero || kind.nonzero || kind.hex_letter)) ok_tk[OK_HEX] = 1'b0;
      lz_tk = (lz_r == LZ_EMPTY && kind.zero) ? LZ_ZERO : LZ_OTHER;
    end
  end

  // Classification with priority decimal, octal, hex, none
  always_comb begin
    ended = is_sep || last_in;
    if ((ok_tk[OK_DEC] && dec_tk == DEC_FINAL) || lz_tk == LZ_ZERO) begin
      cls = CLS_DEC;
    end else if (ok_tk[OK_OCT] && oct_tk == OCT_FINAL) begin
      cls = CLS_OCT;
    end else if (ok_tk[OK_HEX] && hex_tk == HEX_FINAL) begin
      cls = CLS_HEX;
    end else begin
      cls = CLS_NONE;
    end
    result.ended = ended;
    result.cls   = cls;
  end

  // Next word state: cleared when the word ends
  always_comb begin
    dec_nxt = dec_r;
    oct_nxt = oct_r;
    hex_nxt = hex_r;
    ok_nxt  = ok_r;
    lz_nxt  = lz_r;
    if (step_en) begin
      if (ended) begin
        dec_nxt = DEC_START;
        oct_nxt = OCT_START;
        hex_nxt = HEX_START;
        ok_nxt  = '1;
        lz_nxt  = LZ_EMPTY;
      end else begin
        dec_nxt = dec_tk;
        oct_nxt = oct_tk;
        hex_nxt = hex_tk;
        ok_nxt  = ok_tk;
        lz_nxt  = lz_tk;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r <= DEC_START;
      oct_r <= OCT_START;
      hex_r <= HEX_START;
      ok_r  <= '1;
      lz_r  <= LZ_EMPTY;
    end else begin
      dec_r <= dec_nxt;
      oct_r <= oct_nxt;
      hex_r <= hex_nxt;
      ok_r  <= ok_nxt;
      lz_r  <= lz_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/nlc_class_counter.sv -----
// Four saturating word-class counters.
`default_nettype none

module nlc_class_counter #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                                    clk,
  input  logic                                                    rst_n,
  input  logic                                                    step_en,
  input  nlc_pkg::word_result_t                                   result,
  output logic [nlc_pkg::NUM_CLASSES-1:0][nlc_pkg::OUT_CNT_W-1:0] count_out
);
  import nlc_pkg::*;

  localparam int ExtW = (COUNT_WIDTH > OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;

  logic [NUM_CLASSES-1:0][COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [NUM_CLASSES-1:0][ExtW-1:0]        cnt_ext;

  // Counts after this word: only the selected class moves, stopping at full scale
  always_comb begin
    for (int i = 0; i < NUM_CLASSES; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (result.cls == cls_t'(i) && !(&cnt_r[i])) begin
        cnt_nxt[i] = cnt_r[i] + 1'b1;
      end
      cnt_ext[i]   = ExtW'(cnt_nxt[i]);
      count_out[i] = cnt_ext[i][OUT_CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (step_en && result.ended) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/nlc_assert_mon.sv -----
// Port-level assertions for the literal classifier and their bind.
`default_nettype none

`include "numeric_literal_classifier_assert.svh"

module nlc_assert_mon (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [7:0]  in_tdata,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  logic        in_stall;
  logic        out_stall;
  logic [8:0]  in_word;
  logic [65:0] out_word;

  // Stall conditions and the payload each side must hold
  assign in_stall  = in_tvalid && !in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign in_word   = {in_tlast, in_tdata};
  assign out_word  = {out_tuser, out_tdata};

  // Nothing is offered in the cycle after reset
  `NLC_ASSERT_ALWAYS(a_idle_after_reset, !rst_n |=> !out_tvalid, "result offered after reset")

  // Input back-pressure only ever comes from a stalled pending result
  `NLC_ASSERT(a_stall_cause, !in_tready |-> out_stall, "input stalled without output stall")

  // A stalled request keeps its character and flag
  `NLC_ASSERT(a_in_hold, in_stall |=> (in_tvalid && $stable(in_word)), "stalled request changed")

  // A stalled result keeps its class and counts
  `NLC_ASSERT(a_out_hold, out_stall |=> (out_tvalid && $stable(out_word)), "stalled result changed")

endmodule

bind numeric_literal_classifier nlc_assert_mon u_assert_mon (.*);

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the numeric literal classifier stream block.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nlc_pkg::*;

  localparam int COUNT_W        = 16;
  localparam int RANDOM_CHARS   = 700;
  localparam int IDLE_LIMIT     = 4000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_ERR_LINES  = 40;

  // Table columns of the three automata
  localparam int DCOL_SIGN  = 0;
  localparam int DCOL_ZERO  = 1;
  localparam int DCOL_DIGIT = 2;
  localparam int OCOL_ZERO  = 0;
  localparam int OCOL_DIGIT = 1;
  localparam int HCOL_X     = 0;
  localparam int HCOL_ZERO  = 1;
  localparam int HCOL_DIGIT = 2;

  // Next-state tables, rows by current state
  localparam logic [0:3][0:2][1:0] DEC_TAB = '{
    '{DEC_SIGN, DEC_DEAD,  DEC_FINAL},
    '{DEC_DEAD, DEC_DEAD,  DEC_FINAL},
    '{DEC_DEAD, DEC_FINAL, DEC_FINAL},
    '{DEC_DEAD, DEC_DEAD,  DEC_DEAD}
  };
  localparam logic [0:2][0:1][1:0] OCT_TAB = '{
    '{OCT_FINAL, OCT_DEAD},
    '{OCT_FINAL, OCT_FINAL},
    '{OCT_DEAD,  OCT_DEAD}
  };
  localparam logic [0:4][0:2][2:0] HEX_TAB = '{
    '{HEX_DEAD, HEX_ZERO,  HEX_DEAD},
    '{HEX_PFX,  HEX_DEAD,  HEX_DEAD},
    '{HEX_DEAD, HEX_FINAL, HEX_FINAL},
    '{HEX_DEAD, HEX_FINAL, HEX_FINAL},
    '{HEX_DEAD, HEX_DEAD,  HEX_DEAD}
  };

  // How a generated word is closed
  typedef enum int {
    END_SEP,
    END_LAST_CHAR,
    END_LAST_SEP
  } word_end_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_req_t;

  // One word result: class and the four counts, decimal count in slot 0
  typedef struct packed {
    cls_t             word_class;
    logic [3:0][15:0] counts;
  } word_result_exp_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;

  numeric_literal_classifier #(
    .COUNT_WIDTH(COUNT_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  char_req_t        pending_chars[$];
  word_result_exp_t expected_words[$];
  logic [7:0]       word_buf[$];
  int               chars_queued = 0;
  int               err_cnt      = 0;
  int               idle_cycles  = 0;
  logic             in_acc       = 1'b0;
  logic             out_acc      = 1'b0;
  int               in_gap       = 0;
  int               in_burst     = 0;
  int               out_stall    = 0;
  int               out_burst    = 0;

  // Word state of the predictor
  logic [1:0]         dec_st;
  logic [1:0]         oct_st;
  logic [2:0]         hex_st;
  logic [2:0]         alpha_ok;
  lz_t                lz_st;
  logic [COUNT_W-1:0] word_counts[4];

  string CNT_NAME[4] = '{"decimal_count", "octal_count", "hex_count", "other_count"};

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_ERR_LINES) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic clear_word_state();
    dec_st   = DEC_START;
    oct_st   = OCT_START;
    hex_st   = HEX_START;
    alpha_ok = 3'b111;
    lz_st    = LZ_EMPTY;
  endtask

  // Advance the automata on one accepted character and close the word if it ends here
  task automatic classify_char(input logic [7:0] ch, input logic last);
    logic             is_sign, is_zero, is_nz, is_oct, is_hexl, is_x;
    cls_t             cls;
    word_result_exp_t res;
    is_sign = (ch == CHAR_PLUS) || (ch == CHAR_MINUS);
    is_zero = (ch == CHAR_ZERO);
    is_nz   = (ch >= CHAR_ONE) && (ch <= CHAR_NINE);
    is_oct  = (ch >= CHAR_ONE) && (ch <= CHAR_SEVEN);
    is_hexl = (ch >= CHAR_UC_A) && (ch <= CHAR_UC_F);
    is_x    = (ch == CHAR_LC_X);
    if (ch != CHAR_SEP) begin
      if (is_sign) dec_st = DEC_TAB[dec_st][DCOL_SIGN];
      else if (is_zero) dec_st = DEC_TAB[dec_st][DCOL_ZERO];
      else if (is_nz) dec_st = DEC_TAB[dec_st][DCOL_DIGIT];
      else begin
        dec_st = DEC_DEAD;
        alpha_ok[OK_DEC] = 1'b0;
      end
      if (is_zero) oct_st = OCT_TAB[oct_st][OCOL_ZERO];
      else if (is_oct) oct_st = OCT_TAB[oct_st][OCOL_DIGIT];
      else begin
        oct_st = OCT_DEAD;
        alpha_ok[OK_OCT] = 1'b0;
      end
      if (is_x) hex_st = HEX_TAB[hex_st][HCOL_X];
      else if (is_zero) hex_st = HEX_TAB[hex_st][HCOL_ZERO];
      else if (is_nz || is_hexl) hex_st = HEX_TAB[hex_st][HCOL_DIGIT];
      else begin
        hex_st = HEX_DEAD;
        alpha_ok[OK_HEX] = 1'b0;
      end
      lz_st = (lz_st == LZ_EMPTY && is_zero) ? LZ_ZERO : LZ_OTHER;
    end
    if (ch == CHAR_SEP || last) begin
      // priority: decimal (or the lone zero), octal, hex, none
      if ((alpha_ok[OK_DEC] && dec_st == DEC_FINAL) || lz_st == LZ_ZERO) cls = CLS_DEC;
      else if (alpha_ok[OK_OCT] && oct_st == OCT_FINAL) cls = CLS_OCT;
      else if (alpha_ok[OK_HEX] && hex_st == HEX_FINAL) cls = CLS_HEX;
      else cls = CLS_NONE;
      if (word_counts[cls] != {COUNT_W{1'b1}}) word_counts[cls] = word_counts[cls] + 1'b1;
      res.word_class = cls;
      for (int i = 0; i < 4; i++) res.counts[i] = word_counts[i][15:0];
      expected_words.push_back(res);
      clear_word_state();
    end
  endtask

  task automatic push_char(input logic [7:0] ch, input logic last);
    char_req_t r;
    r.ch   = ch;
    r.last = last;
    pending_chars.push_back(r);
    chars_queued++;
  endtask

  // Queue word_buf followed by the chosen ending
  task automatic push_word(input word_end_t how);
    int n;
    n = word_buf.size();
    if (how == END_LAST_CHAR && n > 0) begin
      for (int i = 0; i < n; i++) push_char(word_buf[i], i == n - 1);
    end else begin
      for (int i = 0; i < n; i++) push_char(word_buf[i], 1'b0);
      push_char(CHAR_SEP, how != END_SEP);
    end
  endtask

  task automatic push_text(input string s, input word_end_t how);
    word_buf.delete();
    for (int i = 0; i < s.len(); i++) word_buf.push_back(s[i]);
    push_word(how);
  endtask

  function automatic int body_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 5);
  endfunction

  function automatic logic [7:0] hex_digit();
    int r;
    r = $urandom_range(0, 15);
    return (r < 10) ? 8'(CHAR_ZERO + r) : 8'(CHAR_UC_A + (r - 10));
  endfunction

  // Fill word_buf with one random word, mostly well-formed literals
  task automatic gen_word();
    int    kind, n;
    string near_alpha;
    near_alpha = "+-0123456789ABCDEFxa";
    word_buf.delete();
    kind = $urandom_range(0, 9);
    // broken words start as well-formed ones
    if (kind == 5 || kind == 6) kind = $urandom_range(0, 3) + 10;
    n = body_len();
    case (kind % 10)
      0, 1: begin
        if ($urandom_range(0, 1)) word_buf.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
        word_buf.push_back(8'(CHAR_ONE + $urandom_range(0, 8)));
        for (int i = 0; i < n; i++) word_buf.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
      end
      2: begin
        word_buf.push_back(CHAR_ZERO);
        for (int i = 0; i < n; i++) word_buf.push_back(8'(CHAR_ZERO + $urandom_range(0, 7)));
      end
      3: begin
        word_buf.push_back(CHAR_ZERO);
        word_buf.push_back(CHAR_LC_X);
        for (int i = 0; i <= n; i++) word_buf.push_back(hex_digit());
      end
      4: word_buf.push_back(CHAR_ZERO);
      7: begin
        for (int i = 0; i < $urandom_range(0, 6); i++) word_buf.push_back(8'($urandom_range(0, 255)));
      end
      8: begin
        for (int i = 0; i < $urandom_range(0, 5); i++)
          word_buf.push_back(near_alpha[$urandom_range(0, near_alpha.len() - 1)]);
      end
      default: ;  // empty word
    endcase
    if (kind >= 10 && word_buf.size() > 0)
      word_buf[$urandom_range(0, word_buf.size() - 1)] = 8'($urandom_range(0, 255));
  endtask

  // Idle draw shared by both sides: random gaps, with bursts of no idling
  task automatic draw_idle(inout int burst, output int gap);
    if (burst > 0) begin
      burst--;
      gap = 0;
    end else if ($urandom_range(0, 7) == 0) begin
      burst = $urandom_range(8, 40);
      gap   = 0;
    end else begin
      gap = $urandom_range(0, 14);
    end
  endtask

  // Input driver
  always @(negedge clk) begin : drive_chars
    char_req_t r;
    int        g;
    if (rst_n && (!in_tvalid || in_acc)) begin
      if (in_gap > 0) begin
        in_gap    <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_chars.size() > 0) begin
        r = pending_chars.pop_front();
        draw_idle(in_burst, g);
        in_tdata  <= r.ch;
        in_tlast  <= r.last;
        in_tvalid <= 1'b1;
        in_gap    <= g;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result-side ready
  always @(negedge clk) begin : drive_ready
    int s;
    if (rst_n) begin
      if (out_acc) begin
        draw_idle(out_burst, s);
        out_tready <= (s == 0);
        out_stall  <= (s > 0) ? s - 1 : 0;
      end else if (out_stall > 0) begin
        out_stall  <= out_stall - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Prediction on accepted characters, checking of accepted results
  always @(posedge clk) begin : score_words
    word_result_exp_t e;
    logic             in_fire, out_fire;
    in_fire  = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    in_acc  <= in_fire;
    out_acc <= out_fire;
    if (in_fire) classify_char(in_tdata, in_tlast);
    if (out_fire) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("result with no word pending (class %0d)", out_tuser));
      end else begin
        e = expected_words.pop_front();
        if (out_tuser !== e.word_class)
          report_mismatch($sformatf("word_class got %0d exp %0d", out_tuser, e.word_class));
        for (int i = 0; i < 4; i++) begin
          if (out_tdata[16*i +: 16] !== e.counts[i])
            report_mismatch($sformatf("%s got %0d exp %0d", CNT_NAME[i],
                                      out_tdata[16*i +: 16], e.counts[i]));
        end
      end
    end
    // watchdog on cycles without any accepted request
    if (in_fire || out_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[numeric_literal_classifier] ERROR");
      $finish;
    end
  end

  initial begin
    int target;
    clear_word_state();
    for (int i = 0; i < 4; i++) word_counts[i] = '0;

    // Directed words: empty word, lone zero, each class, both ways of ending the
    // string, zero byte and all-ones byte, a bad octal digit
    push_text("", END_SEP);
    push_text("0", END_SEP);
    push_text("00", END_SEP);
    push_text("0x1F", END_LAST_CHAR);
    push_text("+9", END_LAST_SEP);
    push_char(8'h00, 1'b0);
    push_char(CHAR_SEP, 1'b0);
    push_char(8'hFF, 1'b1);
    push_text("08", END_SEP);
    push_text("-0", END_SEP);

    // Random words with random endings
    target = chars_queued + RANDOM_CHARS;
    while (chars_queued < target) begin
      gen_word();
      case ($urandom_range(0, 5))
        4:       push_word(END_LAST_CHAR);
        5:       push_word(END_LAST_SEP);
        default: push_word(END_SEP);
      endcase
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_chars.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_words.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_words.size()));
    if (err_cnt == 0) begin
      $display("[numeric_literal_classifier] OK");
    end else begin
      $display("[numeric_literal_classifier] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
